[design/atcw_pkg.sv]
// Package: console geometry, byte codes, phase and sequencer types, item structs.
package atcw_pkg;

    localparam int COLS   = 80;
    localparam int ROWS   = 50;
    localparam int CELLS  = COLS * ROWS;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CELL_W = 16;

    localparam logic [7:0] CH_ESC     = 8'd27;
    localparam logic [7:0] CH_CSI     = 8'h5B;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_LF      = 8'd10;
    localparam logic [7:0] CH_SEP     = 8'h3B;
    localparam logic [7:0] FIN_CLEAR  = 8'h4A;
    localparam logic [7:0] FIN_COLOUR = 8'h6D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] ATTR_BLANK = 8'h07;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_READ = 1'b1;

    typedef enum logic [1:0] {
        PH_TEXT = 2'd0,
        PH_ESC  = 2'd1,
        PH_SEQ  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        SQ_CLEAR = 2'd0,
        SQ_RUN   = 2'd1,
        SQ_READ  = 2'd2
    } t_seq_state;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       last_of_write;
        logic [6:0] col;
        logic [5:0] row;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_attr;
        logic       out_of_range;
        logic [6:0] cursor_col;
        logic [5:0] cursor_row;
        logic       refresh_request;
    } t_out_item;

    // Parser to sequencer: store write, clear request and cursor.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CELL_W-1:0] wdata;
        logic              clear;
        logic [6:0]        cur_col;
        logic [5:0]        cur_row;
        logic [6:0]        next_col;
        logic [5:0]        next_row;
    } t_parse_out;

endpackage

[design/atcw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module atcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4000,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/atcw_parser.sv]
// Console byte parser: escape phases, SGR colours, cursor and cell write request.
module atcw_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output atcw_pkg::t_parse_out o_po
);

    atcw_pkg::t_phase r_phase, n_phase;
    logic [6:0]  r_cur_x, n_cur_x;
    logic [5:0]  r_cur_y, n_cur_y;
    logic [3:0]  r_fore, n_fore;
    logic [2:0]  r_back, n_back;
    logic [7:0]  r_param, n_param;
    logic [3:0]  r_pfore, n_pfore;
    logic [2:0]  r_pback, n_pback;

    logic [7:0]  x_w;
    logic [6:0]  y_w;
    logic [11:0] acc;
    logic        is_letter;
    logic        is_digit;
    logic        wr;
    logic        clr;

    // Apply one parameter to a colour pair {fore, back}.
    function automatic logic [6:0] apply_param(input logic [7:0] v,
                                               input logic [3:0] f,
                                               input logic [2:0] b);
        logic [3:0] nf;
        logic [2:0] nb;
        nf = f;
        nb = b;
        if (v == 8'd0) begin
            nf = 4'd7;
            nb = 3'd0;
        end
        if (v >= 8'd30 && v <= 8'd37) begin
            nf = {1'b0, 3'(v - 8'd30)};
        end
        if (v >= 8'd40 && v <= 8'd47) begin
            nb = 3'(v - 8'd40);
        end
        return {nf, nb};
    endfunction

    assign is_letter = (i_byte >= 8'h41 && i_byte <= 8'h5A) ||
                       (i_byte >= 8'h61 && i_byte <= 8'h7A);
    assign is_digit  = (i_byte >= 8'h30 && i_byte <= 8'h39);
    assign acc       = {1'b0, r_param, 3'b000} + {3'b000, r_param, 1'b0} +
                       {4'd0, i_byte - 8'h30};

    // Next parse phase.
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            atcw_pkg::PH_TEXT: begin
                if (i_byte == atcw_pkg::CH_ESC) n_phase = atcw_pkg::PH_ESC;
            end
            atcw_pkg::PH_ESC: begin
                n_phase = (i_byte == atcw_pkg::CH_CSI) ? atcw_pkg::PH_SEQ
                                                       : atcw_pkg::PH_TEXT;
            end
            atcw_pkg::PH_SEQ: begin
                if (is_letter) n_phase = atcw_pkg::PH_TEXT;
            end
            default: n_phase = atcw_pkg::PH_TEXT;
        endcase
    end

    // Datapath and outputs per phase.
    always_comb begin
        n_fore  = r_fore;
        n_back  = r_back;
        n_param = r_param;
        n_pfore = r_pfore;
        n_pback = r_pback;
        x_w     = {1'b0, r_cur_x};
        y_w     = {1'b0, r_cur_y};
        wr      = 1'b0;
        clr     = 1'b0;
        unique case (r_phase)
            atcw_pkg::PH_TEXT: begin
                if (i_byte == atcw_pkg::CH_CR) begin
                    y_w = y_w + 7'd1;
                end else if (i_byte == atcw_pkg::CH_LF) begin
                    x_w = 8'd0;
                end else if (i_byte != atcw_pkg::CH_ESC) begin
                    wr  = 1'b1;
                    x_w = x_w + 8'd1;
                end
            end
            atcw_pkg::PH_ESC: begin
                if (i_byte == atcw_pkg::CH_CSI) begin
                    n_param = 8'd0;
                    n_pfore = r_fore;
                    n_pback = r_back;
                end
            end
            atcw_pkg::PH_SEQ: begin
                if (is_letter) begin
                    n_param = 8'd0;
                    if (i_byte == atcw_pkg::FIN_CLEAR) begin
                        clr = 1'b1;
                    end else if (i_byte == atcw_pkg::FIN_COLOUR) begin
                        {n_fore, n_back} = apply_param(r_param, r_pfore, r_pback);
                    end
                end else if (is_digit) begin
                    n_param = (acc > 12'd255) ? 8'd255 : acc[7:0];
                end else if (i_byte == atcw_pkg::CH_SEP) begin
                    {n_pfore, n_pback} = apply_param(r_param, r_pfore, r_pback);
                    n_param = 8'd0;
                end
            end
            default: ;
        endcase
        // Wrap column into the next row, then row back to the top.
        if (x_w >= 8'(atcw_pkg::COLS)) begin
            x_w = 8'd0;
            y_w = y_w + 7'd1;
        end
        if (y_w >= 7'(atcw_pkg::ROWS)) begin
            y_w = 7'd0;
        end
        n_cur_x = x_w[6:0];
        n_cur_y = y_w[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= atcw_pkg::PH_TEXT;
            r_cur_x <= '0;
            r_cur_y <= '0;
            r_fore  <= 4'd15;
            r_back  <= 3'd0;
            r_param <= 8'd0;
            r_pfore <= 4'd15;
            r_pback <= 3'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y;
            r_fore  <= n_fore;
            r_back  <= n_back;
            r_param <= n_param;
            r_pfore <= n_pfore;
            r_pback <= n_pback;
        end
    end

    always_comb begin
        o_po.we       = i_step & wr;
        o_po.addr     = atcw_pkg::ADDR_W'(atcw_pkg::ADDR_W'(r_cur_y) *
                        atcw_pkg::ADDR_W'(atcw_pkg::COLS)) +
                        atcw_pkg::ADDR_W'(r_cur_x);
        o_po.wdata    = {i_byte, 1'b0, r_back, r_fore};
        o_po.clear    = i_step & clr;
        o_po.cur_col  = r_cur_x;
        o_po.cur_row  = r_cur_y;
        o_po.next_col = n_cur_x;
        o_po.next_row = n_cur_y;
    end

endmodule

[design/ansi_text_console_writer.sv]
// Top level: ANSI text console writer with cell store, sequencer and result register.
//
// Console bytes (cmd 0) and cell reads (cmd 1) arrive as items on a
// valid/ready input channel. Every item gives exactly one result item on a
// valid/ready output channel. The result is held in an output register, and
// the next item is taken no earlier than the cycle in which the waiting
// result is accepted. Text bytes, control bytes and escape sequence bytes
// stream at one item per cycle while the receiver takes each result. A read
// of a cell inside the console passes through the read state, where the
// registered read port of the cell store gives the cell and no item is
// accepted. A read outside the console answers at once with the out-of-range
// flag. The cell store is one RAM of COLS*ROWS 16-bit cells (character high
// byte, attribute low byte). After reset, and after every ESC [ ... J
// sequence, the sequencer sweeps the store with space and attribute 7, one
// cell a cycle, accepting no item. The result of the J byte itself is
// offered on the output from the first cycle of the sweep.
module ansi_text_console_writer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  atcw_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output atcw_pkg::t_out_item o_out_item
);

    atcw_pkg::t_seq_state r_seq, n_seq;
    atcw_pkg::t_parse_out po;
    atcw_pkg::t_out_item  r_out, n_out;

    logic                        r_out_valid, n_out_valid;
    logic [atcw_pkg::ADDR_W-1:0] r_clr_addr, n_clr_addr;

    logic                          accept;
    logic                          rd_cmd;
    logic                          rd_in_range;
    logic                          step;
    logic                          load;
    logic                          clr_last;
    logic                          ram_we;
    logic                          ram_re;
    logic [atcw_pkg::ADDR_W-1:0]   ram_waddr;
    logic [atcw_pkg::ADDR_W-1:0]   ram_raddr;
    logic [atcw_pkg::CELL_W-1:0]   ram_wdata;
    logic [atcw_pkg::CELL_W-1:0]   ram_rdata;

    // Accept only in the run state, and only when the result register frees up.
    assign accept      = i_in_valid & o_in_ready;
    assign rd_cmd      = (i_in_item.cmd == atcw_pkg::CMD_READ);
    assign rd_in_range = ({1'b0, i_in_item.col} < 8'(atcw_pkg::COLS)) &&
                         ({1'b0, i_in_item.row} < 7'(atcw_pkg::ROWS));
    assign step        = accept & (i_in_item.cmd == atcw_pkg::CMD_BYTE);
    assign clr_last    = (r_clr_addr == atcw_pkg::ADDR_W'(atcw_pkg::CELLS - 1));
    assign ram_raddr   = atcw_pkg::ADDR_W'(atcw_pkg::ADDR_W'(i_in_item.row) *
                         atcw_pkg::ADDR_W'(atcw_pkg::COLS)) +
                         atcw_pkg::ADDR_W'(i_in_item.col);

    atcw_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (i_in_item.data_byte),
        .o_po    (po)
    );

    atcw_ram #(
        .WIDTH (atcw_pkg::CELL_W),
        .DEPTH (atcw_pkg::CELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer next state.
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            atcw_pkg::SQ_CLEAR: begin
                if (clr_last) n_seq = atcw_pkg::SQ_RUN;
            end
            atcw_pkg::SQ_RUN: begin
                if (accept && rd_cmd && rd_in_range) begin
                    n_seq = atcw_pkg::SQ_READ;
                end else if (po.clear) begin
                    n_seq = atcw_pkg::SQ_CLEAR;
                end
            end
            atcw_pkg::SQ_READ: n_seq = atcw_pkg::SQ_RUN;
            default:           n_seq = atcw_pkg::SQ_CLEAR;
        endcase
    end

    // Sequencer outputs: store port control and input ready.
    always_comb begin
        o_in_ready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = po.addr;
        ram_wdata  = po.wdata;
        ram_re     = 1'b0;
        n_clr_addr = '0;
        unique case (r_seq)
            atcw_pkg::SQ_CLEAR: begin
                // Sweep blank cells through the whole store.
                ram_we     = 1'b1;
                ram_waddr  = r_clr_addr;
                ram_wdata  = {atcw_pkg::CH_SPACE, atcw_pkg::ATTR_BLANK};
                n_clr_addr = r_clr_addr + atcw_pkg::ADDR_W'(1);
            end
            atcw_pkg::SQ_RUN: begin
                o_in_ready = !r_out_valid || i_out_ready;
                ram_we     = po.we;
                ram_re     = accept & rd_cmd & rd_in_range;
            end
            atcw_pkg::SQ_READ: ;
            default: ;
        endcase
    end

    // Result register: load from the store read, an out-of-range read, or a byte.
    always_comb begin
        load                  = 1'b0;
        n_out                 = r_out;
        if (r_seq == atcw_pkg::SQ_READ) begin
            load                  = 1'b1;
            n_out.cell_char       = ram_rdata[15:8];
            n_out.cell_attr       = ram_rdata[7:0];
            n_out.out_of_range    = 1'b0;
            n_out.cursor_col      = po.cur_col;
            n_out.cursor_row      = po.cur_row;
            n_out.refresh_request = 1'b0;
        end else if (accept && rd_cmd) begin
            load                  = !rd_in_range;
            n_out.cell_char       = 8'd0;
            n_out.cell_attr       = 8'd0;
            n_out.out_of_range    = 1'b1;
            n_out.cursor_col      = po.cur_col;
            n_out.cursor_row      = po.cur_row;
            n_out.refresh_request = 1'b0;
        end else if (accept) begin
            load                  = 1'b1;
            n_out.cell_char       = 8'd0;
            n_out.cell_attr       = 8'd0;
            n_out.out_of_range    = 1'b0;
            n_out.cursor_col      = po.next_col;
            n_out.cursor_row      = po.next_row;
            n_out.refresh_request = i_in_item.last_of_write;
        end
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= atcw_pkg::SQ_CLEAR;
            r_out_valid <= 1'b0;
            r_clr_addr  <= '0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            r_clr_addr  <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef NO_ASSERTIONS
    // A store read always lands in the result register as it leaves the read state.
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq == atcw_pkg::SQ_READ) |=> r_out_valid)
        else $error("store read did not produce a result");

    // An accepted in-range read moves the sequencer to the read state.
    a_read_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && rd_cmd && rd_in_range) |=> (r_seq == atcw_pkg::SQ_READ))
        else $error("in-range read not sequenced");

    // Out-of-range results carry no cell contents.
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.out_of_range) |->
        (o_out_item.cell_char == 8'd0 && o_out_item.cell_attr == 8'd0 &&
         !o_out_item.refresh_request))
        else $error("out-of-range result carries data");

    // The reported cursor always lies inside the console.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (({1'b0, o_out_item.cursor_col} < 8'(atcw_pkg::COLS)) &&
                         ({1'b0, o_out_item.cursor_row} < 7'(atcw_pkg::ROWS))))
        else $error("cursor outside console");
`endif

endmodule

[tb/ansi_text_console_writer_tb.sv]
// Self-checking testbench for the ANSI text console writer: shadow console, scoreboard, traffic.
module ansi_text_console_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import atcw_pkg::*;

    localparam int HOLD_CYCLES   = 300;    // long receiver hold-off
    localparam int STALL_LIMIT   = 20000;  // longer than a clear sweep of the whole store
    localparam int ITEM_GOAL     = 1150;
    localparam int SETTLE_CYCLES = 50;

    // Shadow copy of the console. Every accepted item runs through it, and the
    // result it produces waits in due_results until the block delivers its own.
    class console_mirror;
        bit [7:0]    chars [CELLS];
        bit [7:0]    attrs [CELLS];
        int unsigned cur_x;
        int unsigned cur_y;
        bit [3:0]    fore;
        bit [2:0]    back;
        bit [3:0]    pend_fore;
        bit [2:0]    pend_back;
        t_phase      phase;
        int unsigned param;
        t_out_item   due_results[$];
        int          failures;
        int          n_bytes, n_reads, n_outside, n_clears, n_colour, n_row_wraps;

        function new();
            blank_store();
            cur_x     = 0;
            cur_y     = 0;
            fore      = 4'd15;
            back      = 3'd0;
            pend_fore = 4'd15;
            pend_back = 3'd0;
            phase     = PH_TEXT;
            param     = 0;
        endfunction

        function void blank_store();
            foreach (chars[i]) begin
                chars[i] = CH_SPACE;
                attrs[i] = ATTR_BLANK;
            end
        endfunction

        // One SGR parameter onto the pending colours.
        function void apply_sgr(int unsigned v);
            if (v == 0) begin
                pend_fore = 4'd7;
                pend_back = 3'd0;
            end
            if (v >= 30 && v <= 37) pend_fore = 4'(v - 30);
            if (v >= 40 && v <= 47) pend_back = 3'(v - 40);
        endfunction

        function void console_byte(bit [7:0] b);
            bit          is_alpha;
            int unsigned acc;
            is_alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
            case (phase)
                PH_ESC: begin
                    if (b == CH_CSI) begin
                        phase     = PH_SEQ;
                        param     = 0;
                        pend_fore = fore;
                        pend_back = back;
                    end else begin
                        phase = PH_TEXT;
                    end
                end
                PH_SEQ: begin
                    if (is_alpha) begin
                        phase = PH_TEXT;
                        if (b == FIN_CLEAR) begin
                            blank_store();
                            n_clears++;
                        end else if (b == FIN_COLOUR) begin
                            apply_sgr(param);
                            fore = pend_fore;
                            back = pend_back;
                            n_colour++;
                        end
                        param = 0;
                    end else if (b >= "0" && b <= "9") begin
                        acc   = param * 10 + (b - 8'h30);
                        param = (acc > 255) ? 255 : acc;
                    end else if (b == CH_SEP) begin
                        apply_sgr(param);
                        param = 0;
                    end
                end
                default: begin
                    if (b == CH_CR) begin
                        cur_y++;
                    end else if (b == CH_LF) begin
                        cur_x = 0;
                    end else if (b == CH_ESC) begin
                        phase = PH_ESC;
                    end else begin
                        chars[cur_y * COLS + cur_x] = b;
                        attrs[cur_y * COLS + cur_x] = {1'b0, back, fore};
                        cur_x++;
                    end
                end
            endcase
            if (cur_x >= COLS) begin
                cur_x = 0;
                cur_y++;
            end
            if (cur_y >= ROWS) begin
                cur_y = 0;
                n_row_wraps++;
            end
        endfunction

        // Accepted input item: advance the shadow and queue the result it causes.
        function void note_item(t_in_item it);
            t_out_item r;
            r = '0;
            if (it.cmd == CMD_BYTE) begin
                console_byte(it.data_byte);
                r.refresh_request = it.last_of_write;
                n_bytes++;
            end else begin
                n_reads++;
                if (it.col >= COLS || it.row >= ROWS) begin
                    r.out_of_range = 1'b1;
                    n_outside++;
                end else begin
                    r.cell_char = chars[it.row * COLS + it.col];
                    r.cell_attr = attrs[it.row * COLS + it.col];
                end
            end
            r.cursor_col = 7'(cur_x);
            r.cursor_row = 6'(cur_y);
            due_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        // Accepted result item: compare with the oldest waiting expectation.
        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                $error("result 0x%h arrived with nothing expected", got);
                failures++;
                return;
            end
            want = due_results.pop_front();
            compare_field("cell_char", want.cell_char, got.cell_char);
            compare_field("cell_attr", want.cell_attr, got.cell_attr);
            compare_field("out_of_range", want.out_of_range, got.out_of_range);
            compare_field("cursor_col", want.cursor_col, got.cursor_col);
            compare_field("cursor_row", want.cursor_row, got.cursor_row);
            compare_field("refresh_request", want.refresh_request, got.refresh_request);
        endfunction
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;

    console_mirror sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;
    int items_sent     = 0;
    int quiet_cycles   = 0;

    ansi_text_console_writer DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Monitor: note inputs, check results, and end the run if traffic stops.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_item(in_item);
            if (out_valid && out_ready) sb.check_result(out_item);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("ansi_text_console_writer_tb: errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, or one long hold-off counted here on request.
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item, after a random idle gap, and hold it until accepted.
    task automatic send_item(input t_in_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_byte(input bit [7:0] b, input bit last = 1'b0);
        t_in_item it;
        it.cmd           = CMD_BYTE;
        it.data_byte     = b;
        it.last_of_write = last;
        it.col           = 7'($urandom);   // ignored for console bytes
        it.row           = 6'($urandom);
        send_item(it);
    endtask

    task automatic send_read(input int unsigned c, input int unsigned r);
        t_in_item it;
        it.cmd           = CMD_READ;
        it.data_byte     = 8'($urandom);   // ignored for reads
        it.last_of_write = 1'($urandom);
        it.col           = 7'(c);
        it.row           = 6'(r);
        send_item(it);
    endtask

    // Printable bytes: mostly ASCII, sometimes any byte other than CR, LF or ESC.
    task automatic send_text_run(input int n);
        bit [7:0] b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) != 0) begin
                b = 8'($urandom_range(8'h20, 8'h7E));
            end else begin
                do b = 8'($urandom); while (b == CH_CR || b == CH_LF || b == CH_ESC);
            end
            send_byte(b, (i == n - 1) && $urandom_range(1));
        end
    endtask

    task automatic send_number(input int unsigned v);
        string digits;
        digits = $sformatf("%0d", v);
        for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
    endtask

    // ESC [ p ; p ; ... m with the odd stray byte mixed into the parameters.
    task automatic send_sgr();
        int          n;
        int unsigned v;
        bit [7:0]    junk;
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        n = $urandom_range(0, 3);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(5))
                0:       v = 0;
                1, 2:    v = $urandom_range(30, 37);
                3, 4:    v = $urandom_range(40, 47);
                default: v = $urandom_range(0, 999);
            endcase
            send_number(v);
            if ($urandom_range(5) == 0) begin
                do junk = 8'($urandom);
                while ((junk >= "0" && junk <= "9") || junk == CH_SEP ||
                       (junk >= "A" && junk <= "Z") || (junk >= "a" && junk <= "z"));
                send_byte(junk);
            end
            if (k < n - 1 || $urandom_range(7) == 0) send_byte(CH_SEP);
        end
        send_byte(FIN_COLOUR, 1'($urandom));
    endtask

    // ESC [ optional-number final: clear, or a final the block ignores.
    task automatic send_final(input bit [7:0] fin);
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        if ($urandom_range(1)) send_number($urandom_range(0, 99));
        send_byte(fin, 1'($urandom));
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.due_results.size() != 0);
    endtask

    task automatic random_action();
        int unsigned pick;
        int unsigned c;
        int unsigned r;
        bit [7:0]    b;
        pick = $urandom_range(99);
        if (pick < 34) begin
            // long runs now and then so the cursor wraps a column
            if ($urandom_range(19) == 0) send_text_run($urandom_range(60, 100));
            else send_text_run($urandom_range(1, 12));
        end else if (pick < 44) begin
            case ($urandom_range(7))
                0, 1, 2: send_byte(CH_CR, 1'($urandom));
                3, 4:    send_byte(CH_LF, 1'($urandom));
                5, 6: begin
                    send_byte(CH_CR);
                    send_byte(CH_LF, 1'($urandom));
                end
                default: repeat ($urandom_range(10, 60)) send_byte(CH_CR);
            endcase
        end else if (pick < 58) begin
            send_sgr();
        end else if (pick < 60) begin
            send_final(FIN_CLEAR);
        end else if (pick < 64) begin
            do begin
                if ($urandom_range(1)) b = 8'($urandom_range(8'h41, 8'h5A));
                else b = 8'($urandom_range(8'h61, 8'h7A));
            end while (b == FIN_CLEAR || b == FIN_COLOUR);
            send_final(b);
        end else if (pick < 70) begin
            case ($urandom_range(2))
                0: begin
                    // broken escape: anything but '[' after ESC is dropped
                    do b = 8'($urandom); while (b == CH_CSI);
                    send_byte(CH_ESC);
                    send_byte(b);
                end
                1: begin
                    send_byte(CH_ESC);
                    send_byte(CH_ESC);
                end
                default: send_byte(8'($urandom), 1'($urandom));
            endcase
        end else begin
            case ($urandom_range(2))
                0: begin
                    c = $urandom_range(COLS - 1);
                    r = $urandom_range(ROWS - 1);
                end
                1: begin
                    // look back along the row being written
                    c = (sb.cur_x == 0) ? 0 : $urandom_range(sb.cur_x - 1);
                    r = sb.cur_y;
                end
                default: begin
                    c = $urandom_range(127);
                    r = $urandom_range(63);
                end
            endcase
            send_read(c, r);
        end
    endtask

    initial begin
        int target;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: blank store, out-of-range reads, byte extremes, controls,
        // a dropped escape, a saturating parameter, colour, stray byte, clear.
        send_read(0, 0);
        send_read(COLS - 1, ROWS - 1);
        send_read(127, 63);
        send_read(COLS, 10);
        send_read(5, ROWS);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_byte(CH_ESC);
        send_byte("X");
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        send_byte("9");
        send_byte("9");
        send_byte("9");
        send_byte(CH_SEP);
        send_byte("3");
        send_byte("1");
        send_byte("?");
        send_byte(FIN_COLOUR, 1'b1);
        send_byte("A");
        send_read(0, 1);
        send_final(FIN_CLEAR);
        send_read(0, 1);
        drain();

        // Random traffic in four idling phases, drained between phases.
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            case (phase_no)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (phase_no == 2) begin
                // hold the output while text keeps coming, so the input backs up
                hold_req = 1'b1;
                send_text_run(40);
            end
            target = items_sent + ITEM_GOAL / 4;
            while (items_sent < target) random_action();
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d console bytes and %0d cell reads (%0d outside the console)",
                 sb.n_bytes, sb.n_reads, sb.n_outside);
        $display("with %0d clears, %0d colour sequences and %0d row wraps",
                 sb.n_clears, sb.n_colour, sb.n_row_wraps);
        if (sb.failures == 0) begin
            $display("ansi_text_console_writer_tb: clean");
        end else begin
            $display("ansi_text_console_writer_tb: errors");
        end
        $finish;
    end

endmodule
